### design/ffp_single_divide_defines.svh
// ----------------------------------------------------------------------------
// FFP divide assertion macros
// Shared assertion wrappers for the FFP divide block.
// ----------------------------------------------------------------------------
`ifndef FFP_SINGLE_DIVIDE_DEFINES_SVH
`define FFP_SINGLE_DIVIDE_DEFINES_SVH

// check gated off while reset is asserted
`define FFP_DIV_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check that also holds during reset
`define FFP_DIV_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/ffp_div_pkg.sv
// ----------------------------------------------------------------------------
// FFP divide package
// Widths, types and helpers shared by the FFP divide modules.
// ----------------------------------------------------------------------------
package ffp_div_pkg;

	localparam int MANT_W       = 24;
	localparam int EXP_W        = 7;
	localparam int WORD_W       = 32;
	localparam int FRAC_SHIFT   = 32;
	localparam int NUM_W        = MANT_W + FRAC_SHIFT;
	localparam int POS_W        = 6;
	localparam int T_W          = MANT_W + 1;
	localparam int CNT_W        = 5;
	localparam int LZ_W         = 5;
	localparam int ECALC_W      = 10;
	localparam int EXP_BIAS_ADJ = 33;

	typedef logic [MANT_W-1:0] mant_t;
	typedef logic [EXP_W-1:0]  exp_t;

	typedef struct packed {
		logic [T_W-1:0]   t;
		logic [POS_W-1:0] lead_pos;
		exp_t             exp_dnd;
		exp_t             exp_dsr;
		logic             sign;
	} pack_in_t;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              ovf;
	} pack_out_t;

	// leading zero count of a mantissa
	function automatic logic [LZ_W-1:0] lzc_mant(input mant_t v);
		logic [LZ_W-1:0] cnt;
		cnt = LZ_W'(MANT_W);
		for (int i = 0; i < MANT_W; i++) begin
			if (v[i]) begin
				cnt = LZ_W'(MANT_W - 1 - i);
			end
		end
		return cnt;
	endfunction

endpackage

### design/ffp_div_step.sv
// ----------------------------------------------------------------------------
// FFP divide step
// One restoring division step: shift in a bit, compare, subtract.
// ----------------------------------------------------------------------------
module ffp_div_step (
	input  ffp_div_pkg::mant_t rem,
	input  logic               nbit,
	input  ffp_div_pkg::mant_t dsr,
	output ffp_div_pkg::mant_t rem_next,
	output logic               qbit
);
	import ffp_div_pkg::*;

	logic [MANT_W:0]   rem_sh;
	logic [MANT_W+1:0] diff;

	assign rem_sh   = {rem, nbit};
	assign diff     = {1'b0, rem_sh} - {2'b00, dsr};
	assign qbit     = ~diff[MANT_W+1];
	assign rem_next = qbit ? diff[MANT_W-1:0] : rem_sh[MANT_W-1:0];

endmodule

### design/ffp_div_pack.sv
// ----------------------------------------------------------------------------
// FFP divide pack
// Rounds the quotient mantissa, forms the exponent and packs the word,
// saturating it when the exponent is out of range.
module ffp_div_pack (
	input  ffp_div_pkg::pack_in_t  pin,
	output ffp_div_pkg::pack_out_t pout
);
	import ffp_div_pkg::*;

	logic [MANT_W:0]          mant_sum;
	logic                     carry;
	mant_t                    mant;
	logic signed [ECALC_W-1:0] e;

	assign mant_sum = {1'b0, pin.t[T_W-1:1]} + {{MANT_W{1'b0}}, pin.t[0]};
	assign carry    = mant_sum[MANT_W];
	assign mant     = carry ? {1'b1, {(MANT_W-1){1'b0}}} : mant_sum[MANT_W-1:0];

	assign e = $signed({{(ECALC_W-EXP_W){1'b0}}, pin.exp_dnd})
		- $signed({{(ECALC_W-EXP_W){1'b0}}, pin.exp_dsr})
		+ $signed({{(ECALC_W-POS_W){1'b0}}, pin.lead_pos})
		+ $signed(ECALC_W'(EXP_BIAS_ADJ))
		+ $signed({{(ECALC_W-1){1'b0}}, carry});

	always_comb begin
		if (e < 0 || e > $signed(ECALC_W'((1 << EXP_W) - 1))) begin
			pout.word = {{MANT_W{1'b1}}, pin.sign, {EXP_W{1'b1}}};
			pout.ovf  = 1'b1;
		end else begin
			pout.word = {mant, pin.sign, e[EXP_W-1:0]};
			pout.ovf  = 1'b0;
		end
	end

endmodule

### design/ffp_single_divide.sv
// ----------------------------------------------------------------------------
// FFP single divide
// Divides two fast floating point words by restoring long division,
// one quotient bit per cycle through a shared compare/subtract step.
// ----------------------------------------------------------------------------
// A zero dividend or divisor gives a valid result word in the cycle after
// acceptance; otherwise the word passes through a load cycle, the division
// steps, which stop early once the quotient holds all its bits, and a
// rounding cycle. The step unit is the only divider hardware, so in_ready
// stays low until the word is taken.
// Reset: asynchronous, returns to idle with no result word pending.
`include "ffp_single_divide_defines.svh"

module ffp_single_divide (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] divisor,
	input  logic [31:0] dividend,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] quotient,
	output logic        zero_flag,
	output logic        negative_flag,
	output logic        overflow_flag
);
	import ffp_div_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_DIV,
		S_PACK,
		S_OUT
	} state_t;

	state_t            state_q;
	mant_t             m1_q;
	mant_t             m2_q;
	exp_t              exp_dsr_q;
	exp_t              exp_dnd_q;
	logic              sign_q;
	mant_t             rem_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  lead_q;
	logic              found_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [T_W-1:0]    qs_q;
	logic [WORD_W-1:0] quotient_q;
	logic              zero_q;
	logic              neg_q;
	logic              ovf_q;

	mant_t             in_m1;
	mant_t             in_m2;
	logic [LZ_W-1:0]   lz1;
	logic [LZ_W-1:0]   lz2;
	logic [POS_W-1:0]  start_j;
	logic [NUM_W-1:0]  num_sh;
	logic [POS_W-1:0]  pos_off;
	logic              nbit;
	mant_t             rem_next;
	logic              qbit;
	logic              last_step;
	logic [CNT_W-1:0]  t_shift;
	pack_in_t          pin;
	pack_out_t         pout;

	assign in_m1 = divisor[WORD_W-1:WORD_W-MANT_W];
	assign in_m2 = dividend[WORD_W-1:WORD_W-MANT_W];

	assign lz1     = lzc_mant(m1_q);
	assign lz2     = lzc_mant(m2_q);
	assign start_j = POS_W'(EXP_BIAS_ADJ) + POS_W'(lz1) - POS_W'(lz2);
	assign num_sh  = {m2_q, {FRAC_SHIFT{1'b0}}} >> start_j;

	assign pos_off = pos_q - POS_W'(FRAC_SHIFT);
	assign nbit    = (pos_q >= POS_W'(FRAC_SHIFT)) ? m2_q[pos_off[LZ_W-1:0]] : 1'b0;

	ffp_div_step u_step (
		.rem      (rem_q),
		.nbit     (nbit),
		.dsr      (m1_q),
		.rem_next (rem_next),
		.qbit     (qbit)
	);

	assign last_step = (pos_q == '0) || (found_q && cnt_q == CNT_W'(T_W - 1));
	assign t_shift   = CNT_W'(T_W) - cnt_q;

	assign pin.t        = qs_q << t_shift;
	assign pin.lead_pos = lead_q;
	assign pin.exp_dnd  = exp_dnd_q;
	assign pin.exp_dsr  = exp_dsr_q;
	assign pin.sign     = sign_q;

	ffp_div_pack u_pack (
		.pin  (pin),
		.pout (pout)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			found_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						m1_q      <= in_m1;
						m2_q      <= in_m2;
						exp_dsr_q <= divisor[EXP_W-1:0];
						exp_dnd_q <= dividend[EXP_W-1:0];
						sign_q    <= divisor[EXP_W] ^ dividend[EXP_W];
						if (in_m2 == '0) begin
							quotient_q <= '0;
							zero_q     <= 1'b1;
							neg_q      <= 1'b0;
							ovf_q      <= 1'b0;
							state_q    <= S_OUT;
						end else if (in_m1 == '0) begin
							quotient_q <= '0;
							zero_q     <= 1'b0;
							neg_q      <= 1'b0;
							ovf_q      <= 1'b1;
							state_q    <= S_OUT;
						end else begin
							state_q <= S_LOAD;
						end
					end
				end
				S_LOAD: begin
					rem_q   <= num_sh[MANT_W-1:0];
					pos_q   <= start_j - POS_W'(1);
					found_q <= 1'b0;
					cnt_q   <= '0;
					qs_q    <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= rem_next;
					pos_q <= pos_q - POS_W'(1);
					if (found_q || qbit) begin
						qs_q  <= {qs_q[T_W-2:0], qbit};
						cnt_q <= cnt_q + CNT_W'(1);
					end
					if (!found_q && qbit) begin
						found_q <= 1'b1;
						lead_q  <= pos_q;
					end
					if (last_step) begin
						state_q <= S_PACK;
					end
				end
				S_PACK: begin
					quotient_q <= pout.word;
					zero_q     <= 1'b0;
					neg_q      <= sign_q;
					ovf_q      <= pout.ovf;
					state_q    <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = (state_q == S_OUT);
	assign quotient      = quotient_q;
	assign zero_flag     = zero_q;
	assign negative_flag = neg_q;
	assign overflow_flag = ovf_q;

	`FFP_DIV_ASSERT_ALWAYS(a_no_overlap, !(in_ready && out_valid), "ready while word pending")
	`FFP_DIV_ASSERT(a_flags_excl, out_valid |-> !(zero_flag && overflow_flag), "zero and overflow both set")
	`FFP_DIV_ASSERT(a_neg_sign, out_valid |-> (negative_flag == quotient[EXP_W]), "negative flag mismatch")
	`FFP_DIV_ASSERT(a_lead_found, (state_q == S_PACK) |-> found_q, "no leading quotient bit")
	`FFP_DIV_ASSERT(a_pos_walk, (state_q == S_DIV) && !last_step |=> (state_q == S_DIV) && (pos_q == $past(pos_q) - POS_W'(1)), "step position out of order")

endmodule
